// ===== hdl/twdls_pkg.sv =====
// ----------------------------------------------------------------------------
// twdls_pkg
// Shared types and constants of the two-wire display link sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package twdls_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int WAIT_W     = 11;
   localparam int BITS_W     = 4;

   localparam logic [0:0]        REG_UNIT_TICKS   = 1'b0;
   localparam logic [7:0]        UNIT_TICKS_RESET = 8'd1;
   localparam logic [BITS_W-1:0] BYTE_BITS        = 4'd8;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_ACK   = 2'd2,
      CMD_STOP  = 2'd3
   } command_type;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_START_A  = 4'd1,
      PH_START_B  = 4'd2,
      PH_WR_BIT   = 4'd3,
      PH_WR_RISE  = 4'd4,
      PH_ACK_POLL = 4'd5,
      PH_ACK_END  = 4'd6,
      PH_STOP_A   = 4'd7,
      PH_STOP_B   = 4'd8,
      PH_STOP_C   = 4'd9,
      PH_STOP_D   = 4'd10
   } phase_type;

   typedef struct packed {
      logic       cmd_valid;
      logic [1:0] command;
      logic [7:0] data_byte;
      logic       dio_in;
   } req_payload_type;

   typedef struct packed {
      logic clk_level;
      logic dio_level;
      logic dio_drive;
      logic ready_res;
      logic done_res;
   } rsp_payload_type;

   typedef struct packed {
      logic        has_cmd;
      command_type cmd;
      logic [7:0]  data_byte;
      logic        dio_in;
   } tick_entry_type;

endpackage

// ===== hdl/twdls_front.sv =====
// ----------------------------------------------------------------------------
// twdls_front
// Request intake: handshake toward the queue and command classification.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module twdls_front (
   input  logic                       req_valid,
   output logic                       req_stall,
   input  twdls_pkg::req_payload_type req_payload,
   input  logic                       q_full,
   output logic                       q_push,
   output twdls_pkg::tick_entry_type  q_entry
);

   always_comb begin
      req_stall         = q_full;
      q_push            = req_valid && !q_full;
      q_entry.has_cmd   = req_payload.cmd_valid;
      q_entry.cmd       = twdls_pkg::command_type'(req_payload.command);
      q_entry.data_byte = req_payload.data_byte;
      q_entry.dio_in    = req_payload.dio_in;
   end

endmodule

// ===== hdl/twdls_queue.sv =====
// ----------------------------------------------------------------------------
// twdls_queue
// Short FIFO of classified ticks between intake and sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module twdls_queue #(
   parameter int DEPTH = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  twdls_pkg::tick_entry_type push_entry,
   output logic                      full,
   input  logic                      pop,
   output logic                      head_valid,
   output twdls_pkg::tick_entry_type head_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   twdls_pkg::tick_entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   always_comb begin
      full       = (count_ff == FULL_COUNT);
      head_valid = (count_ff != '0);
      head_entry = slot_ff[rd_ptr_ff];
      do_push    = push && !full;
      do_pop     = pop && head_valid;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      count_in   = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== hdl/twdls_back.sv =====
// ----------------------------------------------------------------------------
// twdls_back
// Pin sequencer: one tick per cycle when not stalled; result is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module twdls_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [7:0]                 unit_ticks,
   input  logic                       q_valid,
   input  twdls_pkg::tick_entry_type  q_entry,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output twdls_pkg::rsp_payload_type rsp_payload
);

   localparam int WW = twdls_pkg::WAIT_W;
   localparam int BW = twdls_pkg::BITS_W;

   twdls_pkg::phase_type phase_ff, phase_in;
   logic [BW-1:0]   bits_ff, bits_in;
   logic [7:0]      shifter_ff, shifter_in;
   logic [WW-1:0]   wait_ff, wait_in;
   logic            clk_ff, clk_in;
   logic            dio_lvl_ff, dio_lvl_in;
   logic            drive_ff, drive_in;
   logic            rsp_valid_ff, rsp_valid_in;
   twdls_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic [WW-1:0]   unit;
   logic [WW-1:0]   wait2, wait3, wait5;
   logic [BW-1:0]   bits_dec;
   logic            take;
   logic            done;

   always_comb begin
      unit  = (unit_ticks == 8'd0) ? WW'(1) : WW'(unit_ticks);
      wait2 = (unit << 1) - WW'(1);
      wait3 = (unit << 1) + unit - WW'(1);
      wait5 = (unit << 2) + unit - WW'(1);
   end

   always_comb begin
      take         = q_valid && (!rsp_valid_ff || !rsp_stall);
      q_pop        = take;
      phase_in     = phase_ff;
      bits_in      = bits_ff;
      shifter_in   = shifter_ff;
      wait_in      = wait_ff;
      clk_in       = clk_ff;
      dio_lvl_in   = dio_lvl_ff;
      drive_in     = drive_ff;
      done         = 1'b0;
      bits_dec     = bits_ff - 1'b1;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (take) begin
         rsp_valid_in = 1'b1;
         if (phase_ff == twdls_pkg::PH_IDLE) begin
            if (q_entry.has_cmd) begin
               unique case (q_entry.cmd)
                  twdls_pkg::CMD_START: begin
                     drive_in   = 1'b1;
                     clk_in     = 1'b1;
                     dio_lvl_in = 1'b1;
                     wait_in    = wait2;
                     phase_in   = twdls_pkg::PH_START_A;
                  end
                  twdls_pkg::CMD_WRITE: begin
                     drive_in   = 1'b1;
                     shifter_in = q_entry.data_byte;
                     bits_in    = twdls_pkg::BYTE_BITS;
                     clk_in     = 1'b0;
                     dio_lvl_in = q_entry.data_byte[0];
                     wait_in    = wait3;
                     phase_in   = twdls_pkg::PH_WR_RISE;
                  end
                  twdls_pkg::CMD_ACK: begin
                     drive_in = 1'b0;
                     clk_in   = 1'b0;
                     wait_in  = wait5;
                     phase_in = twdls_pkg::PH_ACK_POLL;
                  end
                  default: begin
                     drive_in = 1'b1;
                     clk_in   = 1'b0;
                     wait_in  = wait2;
                     phase_in = twdls_pkg::PH_STOP_A;
                  end
               endcase
            end
         end else if (wait_ff != '0) begin
            wait_in = wait_ff - 1'b1;
         end else begin
            unique case (phase_ff)
               twdls_pkg::PH_START_A: begin
                  dio_lvl_in = 1'b0;
                  wait_in    = wait2;
                  phase_in   = twdls_pkg::PH_START_B;
               end
               twdls_pkg::PH_START_B: begin
                  clk_in = 1'b0;
                  done   = 1'b1;
               end
               twdls_pkg::PH_WR_BIT: begin
                  clk_in     = 1'b0;
                  dio_lvl_in = shifter_ff[0];
                  wait_in    = wait3;
                  phase_in   = twdls_pkg::PH_WR_RISE;
               end
               twdls_pkg::PH_WR_RISE: begin
                  clk_in     = 1'b1;
                  shifter_in = shifter_ff >> 1;
                  bits_in    = bits_dec;
                  if (bits_dec == '0) begin
                     done = 1'b1;
                  end else begin
                     phase_in = twdls_pkg::PH_WR_BIT;
                  end
               end
               twdls_pkg::PH_ACK_POLL: begin
                  if (!q_entry.dio_in) begin
                     clk_in   = 1'b1;
                     wait_in  = wait2;
                     phase_in = twdls_pkg::PH_ACK_END;
                  end
               end
               twdls_pkg::PH_ACK_END: begin
                  done = 1'b1;
               end
               twdls_pkg::PH_STOP_A: begin
                  dio_lvl_in = 1'b0;
                  wait_in    = wait2;
                  phase_in   = twdls_pkg::PH_STOP_B;
               end
               twdls_pkg::PH_STOP_B: begin
                  clk_in   = 1'b1;
                  wait_in  = wait2;
                  phase_in = twdls_pkg::PH_STOP_C;
               end
               twdls_pkg::PH_STOP_C: begin
                  dio_lvl_in = 1'b1;
                  wait_in    = wait2;
                  phase_in   = twdls_pkg::PH_STOP_D;
               end
               twdls_pkg::PH_STOP_D: begin
                  clk_in     = 1'b0;
                  dio_lvl_in = 1'b0;
                  done       = 1'b1;
               end
               default: begin
                  done = 1'b1;
               end
            endcase
            if (done) begin
               phase_in = twdls_pkg::PH_IDLE;
            end
         end
      end
      rsp_payload_in = rsp_payload_ff;
      if (take) begin
         rsp_payload_in.clk_level = clk_in;
         rsp_payload_in.dio_level = dio_lvl_in;
         rsp_payload_in.dio_drive = drive_in;
         rsp_payload_in.ready_res = (phase_in == twdls_pkg::PH_IDLE);
         rsp_payload_in.done_res  = done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= twdls_pkg::PH_IDLE;
         bits_ff      <= '0;
         shifter_ff   <= '0;
         wait_ff      <= '0;
         clk_ff       <= 1'b0;
         dio_lvl_ff   <= 1'b0;
         drive_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         bits_ff      <= bits_in;
         shifter_ff   <= shifter_in;
         wait_ff      <= wait_in;
         clk_ff       <= clk_in;
         dio_lvl_ff   <= dio_lvl_in;
         drive_ff     <= drive_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ===== hdl/two_wire_display_link_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// two_wire_display_link_sequencer_top
// Two-wire display link sequencer: drives clock, data and data enable levels.
//
//   channel  | direction | handshake          | payload
//   req_     | in        | req_valid/stall    | cmd_valid, command, data_byte, dio_in
//   rsp_     | out       | rsp_valid/stall    | clk_level, dio_level, dio_drive, ...
//   csr_     | in/out    | psel/penable/pready| unit_ticks at byte address 0
//
// One request per cycle sustained while rsp_stall is low; each request yields one
// response, registered in a queue slot and then in the sequencer's output register.
// The sequencer state updates only when its output register is free or taken.
// req_stall rises only when the QUEUE_DEPTH-entry queue is full.
// Synchronous active-high reset; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_wire_display_link_sequencer_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  twdls_pkg::req_payload_type            req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output twdls_pkg::rsp_payload_type            rsp_payload,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [twdls_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [twdls_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [twdls_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                  csr_pready
);

   logic [7:0] unit_ticks_ff, unit_ticks_in;
   logic       csr_hit;
   logic       csr_wr;

   logic                      q_full;
   logic                      q_push;
   logic                      q_pop;
   logic                      q_valid;
   twdls_pkg::tick_entry_type q_in_entry;
   twdls_pkg::tick_entry_type q_head;

   always_comb begin
      csr_pready    = 1'b1;
      csr_hit       = (csr_paddr[twdls_pkg::CSR_ADDR_W-1] == twdls_pkg::REG_UNIT_TICKS);
      csr_wr        = csr_psel && csr_penable && csr_pwrite && csr_pready;
      unit_ticks_in = unit_ticks_ff;
      if (csr_wr && csr_hit) begin
         unit_ticks_in = csr_pwdata[7:0];
      end
      csr_prdata = '0;
      if (csr_hit) begin
         csr_prdata = {{(twdls_pkg::CSR_DATA_W - 8){1'b0}}, unit_ticks_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ticks_ff <= twdls_pkg::UNIT_TICKS_RESET;
      end else begin
         unit_ticks_ff <= unit_ticks_in;
      end
   end

   twdls_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_entry     (q_in_entry)
   );

   twdls_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_entry (q_head)
   );

   twdls_back u_back (
      .clock       (clock),
      .reset       (reset),
      .unit_ticks  (unit_ticks_ff),
      .q_valid     (q_valid),
      .q_entry     (q_head),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_csr_write_lands: assert property (@(posedge clock) disable iff (reset)
      (csr_wr && csr_hit) |=> (unit_ticks_ff == $past(csr_pwdata[7:0])))
      else $error("unit_ticks write lost");

   a_drain_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !q_valid) |=> !rsp_valid)
      else $error("response produced without a queued request");

   a_done_is_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.done_res) |-> rsp_payload.ready_res)
      else $error("sequence finished but sequencer not idle");

endmodule

// ===== tb/two_wire_display_link_sequencer_top_tb.sv =====
// ----------------------------------------------------------------------------
// two_wire_display_link_sequencer_top_tb
// Self-checking bench for the two-wire display link sequencer.
//
// Every request is one link tick. The bench feeds a short table of directed
// ticks, then runs well-formed start/write/ack/stop sequences with random
// bytes, random pin samples and some stray or out-of-order commands. Runs
// cover several delay unit settings, zero among them. Every
// response is checked field by field against a tick-level model of the pin
// sequencer that runs in the bench. The sender and the receiver each insert
// random gaps. At one point the receiver holds off long enough for the input
// queue to fill up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_wire_display_link_sequencer_top_tb;

   localparam int AW = twdls_pkg::CSR_ADDR_W;
   localparam int DW = twdls_pkg::CSR_DATA_W;
   localparam int WW = twdls_pkg::WAIT_W;
   localparam logic [AW-1:0] UNIT_TICKS_ADDR = AW'(4 * twdls_pkg::REG_UNIT_TICKS);
   localparam int DIRECTED_ROWS = 22;

   typedef struct {
      twdls_pkg::req_payload_type stim;
      int                         reps;
      bit                         pinned;
      twdls_pkg::rsp_payload_type levels;
   } directed_row_type;

   logic                       clock        = 1'b0;
   logic                       reset        = 1'b1;
   logic                       req_valid    = 1'b0;
   logic                       req_stall;
   twdls_pkg::req_payload_type req_payload  = '0;
   logic                       rsp_valid;
   logic                       rsp_stall    = 1'b0;
   twdls_pkg::rsp_payload_type rsp_payload;
   logic                       csr_psel     = 1'b0;
   logic                       csr_penable  = 1'b0;
   logic                       csr_pwrite   = 1'b0;
   logic [AW-1:0]              csr_paddr    = '0;
   logic [DW-1:0]              csr_pwdata   = '0;
   logic [DW-1:0]              csr_prdata;
   logic                       csr_pready;

   // link model state
   twdls_pkg::phase_type       link_phase;
   twdls_pkg::command_type     link_cmd;
   logic [twdls_pkg::BITS_W-1:0] bits_to_go;
   logic [7:0]                 shift_byte;
   logic [WW-1:0]              ticks_to_wait;
   logic                       clk_q;
   logic                       dio_q;
   logic                       drive_q;
   logic [7:0]                 unit_cfg;

   twdls_pkg::rsp_payload_type expected_levels [$];
   twdls_pkg::command_type     next_cmd;
   int                         send_idle_pct;
   int                         recv_idle_pct;
   int                         hold_left;
   bit                         hold_request;
   int                         errors;
   int                         responses;
   int                         busy_drops;
   int                         cmd_seen [4];
   string                      field_name [5] = '{"clk_level", "dio_level", "dio_drive",
                                                  "ready_res", "done_res"};

   // stim {cmd_valid, command, data_byte, dio_in}; levels {clk, dio, drive, ready, done}
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{{1'b0, twdls_pkg::CMD_START, 8'h00, 1'b0},  1, 1'b1, 5'b00110},
      '{{1'b1, twdls_pkg::CMD_START, 8'h00, 1'b0},  1, 1'b1, 5'b11100},
      '{{1'b1, twdls_pkg::CMD_STOP,  8'hFF, 1'b1},  1, 1'b0, 5'b00000},
      '{{1'b0, twdls_pkg::CMD_WRITE, 8'hFF, 1'b0},  4, 1'b0, 5'b00000},
      '{{1'b1, twdls_pkg::CMD_WRITE, 8'hFF, 1'b1},  1, 1'b1, 5'b01100},
      '{{1'b0, twdls_pkg::CMD_ACK,   8'h00, 1'b1}, 32, 1'b0, 5'b00000},
      '{{1'b1, twdls_pkg::CMD_WRITE, 8'h00, 1'b0},  1, 1'b1, 5'b00100},
      '{{1'b0, twdls_pkg::CMD_STOP,  8'hFF, 1'b1}, 32, 1'b0, 5'b00000},
      '{{1'b1, twdls_pkg::CMD_WRITE, 8'hA5, 1'b0},  1, 1'b0, 5'b00000},
      '{{1'b1, twdls_pkg::CMD_ACK,   8'h3C, 1'b0},  3, 1'b0, 5'b00000},
      '{{1'b0, twdls_pkg::CMD_START, 8'h00, 1'b1}, 29, 1'b0, 5'b00000},
      '{{1'b1, twdls_pkg::CMD_ACK,   8'h00, 1'b1},  1, 1'b0, 5'b00000},
      '{{1'b0, twdls_pkg::CMD_ACK,   8'h00, 1'b1}, 12, 1'b0, 5'b00000},
      '{{1'b0, twdls_pkg::CMD_ACK,   8'h00, 1'b0},  3, 1'b0, 5'b00000},
      '{{1'b1, twdls_pkg::CMD_STOP,  8'h00, 1'b0},  1, 1'b0, 5'b00000},
      '{{1'b0, twdls_pkg::CMD_STOP,  8'h00, 1'b0},  8, 1'b0, 5'b00000},
      '{{1'b1, twdls_pkg::CMD_ACK,   8'h00, 1'b0},  1, 1'b0, 5'b00000},
      '{{1'b0, twdls_pkg::CMD_WRITE, 8'h00, 1'b0},  8, 1'b0, 5'b00000},
      '{{1'b1, twdls_pkg::CMD_WRITE, 8'h5A, 1'b1},  1, 1'b0, 5'b00000},
      '{{1'b0, twdls_pkg::CMD_WRITE, 8'hC3, 1'b1}, 32, 1'b0, 5'b00000},
      '{{1'b1, twdls_pkg::CMD_STOP,  8'h00, 1'b1},  1, 1'b0, 5'b00000},
      '{{1'b0, twdls_pkg::CMD_STOP,  8'h00, 1'b0},  8, 1'b0, 5'b00000}
   };

   two_wire_display_link_sequencer_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   function automatic logic [WW-1:0] span_of(input int units);
      int u;
      u = (unit_cfg == 0) ? 1 : unit_cfg;
      return WW'((units * u - 1) & 'h7FF);
   endfunction

   function automatic void present_bit();
      clk_q         = 1'b0;
      dio_q         = shift_byte[0];
      ticks_to_wait = span_of(3);
      link_phase    = twdls_pkg::PH_WR_RISE;
   endfunction

   // one link tick; returns the pin levels after it
   function automatic twdls_pkg::rsp_payload_type advance_link(
      input twdls_pkg::req_payload_type t);
      twdls_pkg::rsp_payload_type r;
      logic                       fin;
      fin = 1'b0;
      if (link_phase == twdls_pkg::PH_IDLE) begin
         if (t.cmd_valid) begin
            link_cmd = twdls_pkg::command_type'(t.command);
            cmd_seen[t.command]++;
            case (link_cmd)
               twdls_pkg::CMD_START: begin
                  drive_q = 1'b1; clk_q = 1'b1; dio_q = 1'b1;
                  ticks_to_wait = span_of(2);
                  link_phase = twdls_pkg::PH_START_A;
               end
               twdls_pkg::CMD_WRITE: begin
                  drive_q    = 1'b1;
                  shift_byte = t.data_byte;
                  bits_to_go = twdls_pkg::BYTE_BITS;
                  present_bit();
               end
               twdls_pkg::CMD_ACK: begin
                  drive_q = 1'b0; clk_q = 1'b0;
                  ticks_to_wait = span_of(5);
                  link_phase = twdls_pkg::PH_ACK_POLL;
               end
               default: begin
                  drive_q = 1'b1; clk_q = 1'b0;
                  ticks_to_wait = span_of(2);
                  link_phase = twdls_pkg::PH_STOP_A;
               end
            endcase
         end
      end else if (ticks_to_wait != 0) begin
         ticks_to_wait--;
      end else begin
         case (link_phase)
            twdls_pkg::PH_START_A: begin
               dio_q = 1'b0; ticks_to_wait = span_of(2);
               link_phase = twdls_pkg::PH_START_B;
            end
            twdls_pkg::PH_START_B: begin
               clk_q = 1'b0; fin = 1'b1;
            end
            twdls_pkg::PH_WR_BIT: present_bit();
            twdls_pkg::PH_WR_RISE: begin
               clk_q      = 1'b1;
               shift_byte = shift_byte >> 1;
               bits_to_go = bits_to_go - 1'b1;
               if (bits_to_go == 0) fin = 1'b1;
               else link_phase = twdls_pkg::PH_WR_BIT;
            end
            twdls_pkg::PH_ACK_POLL: begin
               if (!t.dio_in) begin
                  clk_q = 1'b1; ticks_to_wait = span_of(2);
                  link_phase = twdls_pkg::PH_ACK_END;
               end
            end
            twdls_pkg::PH_ACK_END: fin = 1'b1;
            twdls_pkg::PH_STOP_A: begin
               dio_q = 1'b0; ticks_to_wait = span_of(2);
               link_phase = twdls_pkg::PH_STOP_B;
            end
            twdls_pkg::PH_STOP_B: begin
               clk_q = 1'b1; ticks_to_wait = span_of(2);
               link_phase = twdls_pkg::PH_STOP_C;
            end
            twdls_pkg::PH_STOP_C: begin
               dio_q = 1'b1; ticks_to_wait = span_of(2);
               link_phase = twdls_pkg::PH_STOP_D;
            end
            twdls_pkg::PH_STOP_D: begin
               clk_q = 1'b0; dio_q = 1'b0; fin = 1'b1;
            end
            default: fin = 1'b1;
         endcase
         if (fin) link_phase = twdls_pkg::PH_IDLE;
      end
      r.clk_level = clk_q;
      r.dio_level = dio_q;
      r.dio_drive = drive_q;
      r.ready_res = (link_phase == twdls_pkg::PH_IDLE);
      r.done_res  = fin;
      return r;
   endfunction

   // call at a rising edge; returns at the edge that accepted the request
   task automatic send_tick(input twdls_pkg::req_payload_type t,
                            input bit pinned = 1'b0,
                            input twdls_pkg::rsp_payload_type levels = '0);
      twdls_pkg::rsp_payload_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= t;
      do @(posedge clock); while (req_stall);
      predicted = advance_link(t);
      expected_levels.push_back(pinned ? levels : predicted);
   endtask

   // finish any sequence in progress, then wait for every response
   task automatic settle_link();
      twdls_pkg::req_payload_type t;
      while (link_phase != twdls_pkg::PH_IDLE) begin
         t = '0;
         t.command   = 2'($urandom_range(3));
         t.data_byte = 8'($urandom_range(255));
         send_tick(t);
      end
      req_valid <= 1'b0;
      while (expected_levels.size() != 0) @(posedge clock);
   endtask

   task automatic set_unit_ticks(input logic [7:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= UNIT_TICKS_ADDR;
      csr_pwdata  <= DW'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[7:0] !== value) begin
         $display("%0t: unit_ticks readback expected %0d actual %0d",
                  $time, value, csr_prdata[7:0]);
         errors++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      unit_cfg = value;
   endtask

   task automatic run_links(input int tick_budget, input int cmd_budget);
      twdls_pkg::req_payload_type t;
      int                         ticks;
      int                         cmds;
      int                         roll;
      bit                         idle;
      ticks = 0;
      cmds  = 0;
      while (ticks < tick_budget && cmds < cmd_budget) begin
         idle        = (link_phase == twdls_pkg::PH_IDLE);
         t.cmd_valid = 1'b0;
         t.command   = 2'($urandom_range(3));
         t.data_byte = 8'($urandom_range(255));
         t.dio_in    = ($urandom_range(99) < 30);
         roll        = $urandom_range(99);
         if (idle) begin
            if (roll < 70) begin
               t.cmd_valid = 1'b1;
               t.command   = next_cmd;
            end else if (roll < 80) begin
               t.cmd_valid = 1'b1;
            end
         end else if (roll < 8) begin
            t.cmd_valid = 1'b1;
         end
         if (idle && t.cmd_valid) begin
            cmds++;
            case (twdls_pkg::command_type'(t.command))
               twdls_pkg::CMD_START: next_cmd = twdls_pkg::CMD_WRITE;
               twdls_pkg::CMD_WRITE: next_cmd = twdls_pkg::CMD_ACK;
               twdls_pkg::CMD_ACK:   next_cmd = $urandom_range(1) ? twdls_pkg::CMD_WRITE
                                                                  : twdls_pkg::CMD_STOP;
               default:              next_cmd = twdls_pkg::CMD_START;
            endcase
         end
         if (idle || !t.cmd_valid) ticks++;
         else busy_drops++;
         send_tick(t);
      end
      settle_link();
   endtask

   // response side: random stall, long hold-off on request, checking
   always @(posedge clock) begin : rsp_side
      twdls_pkg::rsp_payload_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_levels.size() == 0) begin
               $display("%0t: unexpected response, expected none actual %b",
                        $time, rsp_payload);
               errors++;
            end else begin
               want = expected_levels.pop_front();
               for (int i = 0; i < 5; i++) begin
                  if (rsp_payload[4-i] !== want[4-i]) begin
                     $display("%0t: %s expected %b actual %b",
                              $time, field_name[i], want[4-i], rsp_payload[4-i]);
                     errors++;
                  end
               end
               responses++;
            end
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = 60;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   initial begin
      #4ms;
      $display("Verification failed");
      $finish;
   end

   initial begin
      link_phase    = twdls_pkg::PH_IDLE;
      link_cmd      = twdls_pkg::CMD_START;
      bits_to_go    = '0;
      shift_byte    = '0;
      ticks_to_wait = '0;
      clk_q         = 1'b0;
      dio_q         = 1'b0;
      drive_q       = 1'b1;
      unit_cfg      = twdls_pkg::UNIT_TICKS_RESET;
      next_cmd      = twdls_pkg::CMD_START;
      send_idle_pct = 15;
      recv_idle_pct = 78;
      hold_left     = 0;
      hold_request  = 1'b0;
      errors        = 0;
      responses     = 0;
      busy_drops    = 0;
      cmd_seen      = '{0, 0, 0, 0};

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         for (int k = 0; k < directed_rows[r].reps; k++)
            send_tick(directed_rows[r].stim, directed_rows[r].pinned,
                      directed_rows[r].levels);
      end
      settle_link();

      set_unit_ticks(8'd3);
      run_links(180, 1000);

      send_idle_pct = 78;
      recv_idle_pct = 15;
      set_unit_ticks(8'd1);
      run_links(170, 1000);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_unit_ticks(8'd0);
      hold_request = 1'b1;
      run_links(150, 1000);

      set_unit_ticks(8'd6);
      next_cmd = twdls_pkg::CMD_START;
      run_links(100, 1000);

      repeat (10) @(posedge clock);
      $display("Run covered %0d link ticks at unit settings 1, 3, 1, 0 and 6,",
               responses);
      $display("with %0d start, %0d write, %0d ack, %0d stop and %0d busy drops",
               cmd_seen[twdls_pkg::CMD_START], cmd_seen[twdls_pkg::CMD_WRITE],
               cmd_seen[twdls_pkg::CMD_ACK], cmd_seen[twdls_pkg::CMD_STOP], busy_drops);
      if (errors == 0 && expected_levels.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
